// ===== src/drwa_pkg.sv =====
// Shared item types and controller-to-datapath command/status types for the window averager.
package drwa_pkg;

  typedef struct packed {
    logic signed [15:0] temp_sample;
    logic signed [15:0] setpoint_sample;
  } sample_item_t;

  typedef struct packed {
    logic signed [15:0] temp_mean;
    logic signed [15:0] setpoint_mean;
    logic [5:0]         samples_held;
  } result_item_t;

  typedef struct packed {
    logic accept;     // capture the incoming samples, read the old ring entry
    logic update;     // write the ring, adjust sums, advance slot and fill count
    logic load;       // load both dividers from the sums
    logic step;       // one restoring-division step on both lanes
    logic store_out;  // load the result register
  } dp_cmd_t;

  typedef struct packed {
    logic div_last;   // the current division step is the last one
  } dp_sts_t;

endpackage

// ===== src/dual_running_window_average_core.sv =====
// Top level of the dual running-window averager: controller, datapath and checks.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_stall    drwa_pkg::sample_item_t
//   result    out        result_valid / result_stall    drwa_pkg::result_item_t
//
// Sequence: an accepted item passes through update, load, divide and store
//   before the next is taken; its result is offered from the output register
//   once stored. The bit-serial divider resolves one quotient bit a cycle over
//   the SUM_W = 16 + clog2(WINDOW) bit sums.
// The next item is taken as soon as the result sits in the output register,
//   even while result_stall holds it there.
// Reset (rst, synchronous) empties the window: fill count, write slot and
//   sums go to zero; the ring itself is not cleared.
// A stalled result holds the block in its final state until the register frees.
module dual_running_window_average_core #(
  parameter int WINDOW = 50
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_stall,
  input  drwa_pkg::sample_item_t sample,
  output logic                   result_valid,
  input  logic                   result_stall,
  output drwa_pkg::result_item_t result
);

  // Command and status between the sequencer and the datapath.
  drwa_pkg::dp_cmd_t cmd;
  drwa_pkg::dp_sts_t sts;

  // Sequence each item: capture, update sums, load dividers, divide, store.
  drwa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Hold the ring, the running sums and the two dividers.
  drwa_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .sample (sample),
    .result (result)
  );

`ifndef SYNTH
  // An accepted item closes the input until its result is stored.
  a_accept_closes_input: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("input open right after an item was accepted");

  // Never overwrite a result that is still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.store_out |-> !result_valid || !result_stall)
    else $error("result register overwritten while stalled");

  // A stored result is offered on the next cycle.
  a_store_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.store_out |=> result_valid)
    else $error("stored result not offered");

  // The window never reports an empty count, where the count fits the field.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.samples_held != 6'd0) || (WINDOW > 63))
    else $error("result with zero samples held");
`endif

endmodule

// ===== src/drwa_ctrl.sv =====
// Controller state machine and result valid flag for the window averager.
module drwa_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_stall,
  output logic            result_valid,
  input  logic            result_stall,
  input  drwa_pkg::dp_sts_t sts,
  output drwa_pkg::dp_cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_LOAD   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_STORE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   store_ok;
  logic   result_valid_next;

  // The result register is free when empty or emptied this cycle.
  assign store_ok = !result_valid || !result_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (sample_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (store_ok) begin
          cmd.store_out = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.store_out) begin
      result_valid_next = 1'b1;
    end else if (!result_stall) begin
      result_valid_next = 1'b0;
    end else begin
      result_valid_next = result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  assign sample_stall = (state != ST_IDLE);

endmodule

// ===== src/drwa_dp.sv =====
// Datapath: sample ring, running sums, fill count, two serial dividers, result register.
module drwa_dp #(
  parameter int WINDOW = 50
) (
  input  logic                    clk,
  input  logic                    rst,
  input  drwa_pkg::dp_cmd_t       cmd,
  output drwa_pkg::dp_sts_t       sts,
  input  drwa_pkg::sample_item_t  sample,
  output drwa_pkg::result_item_t  result
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int SUM_W  = 16 + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  // Ring entry: temperature in the upper half, setpoint in the lower half.
  logic [31:0]       ring [WINDOW];
  logic [31:0]       rd_data;

  logic [SLOT_W-1:0] slot;
  logic [CNT_W-1:0]  fill;
  logic              full;
  logic [STEP_W-1:0] step_cnt;

  logic signed [15:0]      smp      [2];
  logic signed [15:0]      old_smp  [2];
  logic signed [SUM_W-1:0] sum      [2];
  logic signed [SUM_W-1:0] sum_next [2];
  logic [SUM_W-1:0]        quo      [2];
  logic [CNT_W-1:0]        rem      [2];
  logic                    neg      [2];
  logic [15:0]             mean     [2];

  assign full       = (fill == CNT_W'(WINDOW));
  assign old_smp[0] = signed'(rd_data[31:16]);
  assign old_smp[1] = signed'(rd_data[15:0]);

  // The read port always looks at the current slot; its data is used only
  // after the ring has been filled once.
  always_ff @(posedge clk) begin
    rd_data <= ring[slot];
    if (cmd.update) begin
      ring[slot] <= {smp[0], smp[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      smp[0] <= sample.temp_sample;
      smp[1] <= sample.setpoint_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      fill <= '0;
    end else if (cmd.update) begin
      slot <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      if (!full) begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      step_cnt <= STEP_W'(SUM_W - 1);
    end else if (cmd.step) begin
      step_cnt <= step_cnt - 1'b1;
    end
  end

  assign sts.div_last = (step_cnt == '0);

  for (genvar lane = 0; lane < 2; lane++) begin : g_lane
    logic signed [SUM_W-1:0] old_sub;
    logic [SUM_W-1:0]        mag;
    logic [CNT_W:0]          shifted;
    logic                    fits;
    logic [SUM_W-1:0]        signed_q;

    // Drop the overwritten entry once the ring is full.
    assign old_sub         = full ? SUM_W'(old_smp[lane]) : '0;
    assign sum_next[lane]  = sum[lane] + SUM_W'(smp[lane]) - old_sub;
    assign mag             = sum[lane][SUM_W-1] ? (~sum[lane] + 1'b1) : sum[lane];
    assign shifted         = {rem[lane], quo[lane][SUM_W-1]};
    assign fits            = (shifted >= {1'b0, fill});
    assign signed_q        = neg[lane] ? (~quo[lane] + 1'b1) : quo[lane];
    assign mean[lane]      = signed_q[15:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        sum[lane] <= '0;
      end else if (cmd.update) begin
        sum[lane] <= sum_next[lane];
      end
    end

    // Restoring division of the magnitude by the fill count, one bit a cycle.
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        neg[lane] <= sum[lane][SUM_W-1];
        quo[lane] <= mag;
        rem[lane] <= '0;
      end else if (cmd.step) begin
        quo[lane] <= {quo[lane][SUM_W-2:0], fits};
        rem[lane] <= fits ? CNT_W'(shifted - {1'b0, fill}) : shifted[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_out) begin
      result.temp_mean     <= signed'(mean[0]);
      result.setpoint_mean <= signed'(mean[1]);
      result.samples_held  <= 6'(fill);
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the dual running-window averager: directed table, then random items.
`timescale 1ns / 100ps

module tb_top;

  localparam int WINDOW     = 50;
  localparam int LATENCY    = 26;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT      = 600000;
  localparam int MAX_PRINTS = 100;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_stall;
  drwa_pkg::sample_item_t sample = '0;
  logic                   result_valid;
  logic                   result_stall = 1'b0;
  drwa_pkg::result_item_t result;

  dual_running_window_average_core #(.WINDOW(WINDOW)) u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the rings, slot, fill count and sums.
  logic signed [15:0] temp_hist [WINDOW];
  logic signed [15:0] setp_hist [WINDOW];
  int                 next_slot = 0;
  int                 held = 0;
  longint             temp_total = 0;
  longint             setp_total = 0;

  drwa_pkg::result_item_t pending_means [$];
  int                 mismatch_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  int                 hold_requests = 0;
  int                 holds_seen = 0;
  int                 hold_left = 0;
  int unsigned        cycle_count = 0;

  // Random item shaping: runs of one flavor of content.
  typedef enum int {MIX_FULL, MIX_EXTREMES, MIX_NEAR, MIX_PEGGED} mix_t;
  mix_t               mix = MIX_FULL;
  int                 mix_left = 0;
  logic signed [15:0] near_t, near_s, peg_t, peg_s;

  typedef struct packed {
    logic signed [15:0]     temp;
    logic signed [15:0]     setpoint;
    bit                     known;
    drwa_pkg::result_item_t want;
  } dir_row_t;

  localparam int DIR_ROWS = 14;
  dir_row_t dir_rows [DIR_ROWS];

  // Advance the window by one item and return both means and the fill count.
  function automatic drwa_pkg::result_item_t window_average(
    input drwa_pkg::sample_item_t it);
    drwa_pkg::result_item_t r;
    longint       tm;
    longint       sm;
    if (held >= WINDOW) begin
      // full ring: drop the oldest entry before it is overwritten
      temp_total -= temp_hist[next_slot];
      setp_total -= setp_hist[next_slot];
    end else begin
      held++;
    end
    temp_hist[next_slot] = it.temp_sample;
    setp_hist[next_slot] = it.setpoint_sample;
    temp_total += it.temp_sample;
    setp_total += it.setpoint_sample;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    // SV signed division truncates toward zero
    tm = temp_total / longint'(held);
    sm = setp_total / longint'(held);
    r.temp_mean     = tm[15:0];
    r.setpoint_mean = sm[15:0];
    r.samples_held  = held[5:0];
    return r;
  endfunction

  function automatic logic signed [15:0] extreme_value();
    case ($urandom_range(4))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2:       return -16'sd1;
      3:       return 16'sd0;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic drwa_pkg::sample_item_t next_sample();
    drwa_pkg::sample_item_t it;
    if (mix_left == 0) begin
      mix      = mix_t'($urandom_range(3));
      mix_left = $urandom_range(20, 120);
      near_t   = 16'($urandom);
      near_s   = 16'($urandom);
      peg_t    = extreme_value();
      peg_s    = extreme_value();
    end
    mix_left--;
    case (mix)
      MIX_FULL: begin
        it.temp_sample     = 16'($urandom);
        it.setpoint_sample = 16'($urandom);
      end
      MIX_EXTREMES: begin
        it.temp_sample     = extreme_value();
        it.setpoint_sample = extreme_value();
      end
      MIX_NEAR: begin
        it.temp_sample     = near_t + 16'($urandom_range(64)) - 16'sd32;
        it.setpoint_sample = near_s + 16'($urandom_range(64)) - 16'sd32;
      end
      default: begin
        // hold one extreme long enough to pin the full-window sums
        it.temp_sample     = peg_t;
        it.setpoint_sample = peg_s;
      end
    endcase
    return it;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Offer one item, hold it until taken, and queue what it should produce.
  task automatic offer(input drwa_pkg::sample_item_t it, input bit known,
                       input drwa_pkg::result_item_t want);
    drwa_pkg::result_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    predicted = window_average(it);
    pending_means.push_back(known ? want : predicted);
  endtask

  // Result side: check taken items, then pick the stall for the next edge.
  always @(posedge clk) begin
    drwa_pkg::result_item_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_means.size() == 0) begin
        report_mismatch($sformatf("result %p with no item pending", result));
      end else begin
        want = pending_means.pop_front();
        if (result.temp_mean !== want.temp_mean)
          report_mismatch($sformatf("temp_mean %0d, want %0d",
                                    result.temp_mean, want.temp_mean));
        if (result.setpoint_mean !== want.setpoint_mean)
          report_mismatch($sformatf("setpoint_mean %0d, want %0d",
                                    result.setpoint_mean, want.setpoint_mean));
        if (result.samples_held !== want.samples_held)
          report_mismatch($sformatf("samples_held %0d, want %0d",
                                    result.samples_held, want.samples_held));
      end
    end
    if (hold_requests != holds_seen) begin
      holds_seen = hold_requests;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    drwa_pkg::sample_item_t it;
    drwa_pkg::result_item_t none;
    none = '0;
    foreach (temp_hist[i]) begin
      temp_hist[i] = '0;
      setp_hist[i] = '0;
    end

    dir_rows = '{
      '{16'sh7fff, 16'sh8000, 1'b1, '{16'sh7fff, 16'sh8000, 6'd1}},
      '{16'sh7fff, 16'sh8000, 1'b1, '{16'sh7fff, 16'sh8000, 6'd2}},
      '{16'sh8000, 16'sh7fff, 1'b0, '0},
      '{16'sh0000, 16'sh0000, 1'b0, '0},
      '{-16'sd1,   16'sd1,    1'b0, '0},
      '{16'sd1,    -16'sd1,   1'b0, '0},
      '{16'sh8000, 16'sh8000, 1'b0, '0},
      '{16'sh7fff, 16'sh7fff, 1'b0, '0},
      '{16'sh5555, 16'shaaaa, 1'b0, '0},
      '{16'shaaaa, 16'sh5555, 1'b0, '0},
      '{-16'sd7,   16'sd7,    1'b0, '0},
      '{16'sd100,  -16'sd100, 1'b0, '0},
      '{16'sd2150, 16'sd2000, 1'b0, '0},
      '{-16'sd3,   16'sd3,    1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 9;
    recv_idle_pct <= 67;

    // directed table; the first rows after reset are typed in
    for (int i = 0; i < DIR_ROWS; i++) begin
      it.temp_sample     = dir_rows[i].temp;
      it.setpoint_sample = dir_rows[i].setpoint;
      offer(it, dir_rows[i].known, dir_rows[i].want);
    end

    for (int i = 0; i < 600; i++) offer(next_sample(), 1'b0, none);

    send_idle_pct = 67;
    recv_idle_pct <= 9;
    for (int i = 0; i < 600; i++) offer(next_sample(), 1'b0, none);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    for (int i = 0; i < 550; i++) begin
      // stall the result side for a long stretch so the block backs up
      if (i == 100) hold_requests <= hold_requests + 1;
      offer(next_sample(), 1'b0, none);
    end
    sample_valid <= 1'b0;

    while (pending_means.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
